>>> rtl/aip_pkg.sv
package aip_pkg;

	localparam int VALUE_BITS = 32;
	localparam int POS_BITS   = 12;
	localparam int BASE_BITS  = 6;
	localparam int DIG_BITS   = 6;
	localparam int IDX_BITS   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [POS_BITS-1:0] MAX_TEXT = 12'd4095;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_NUMBER_BASE = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_SIGNED_MODE = 2'd1;

	// radix codes
	localparam logic [BASE_BITS-1:0] BASE_INFER  = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_UNARY  = 6'd1;
	localparam logic [BASE_BITS-1:0] RADIX_MIN   = 6'd2;
	localparam logic [BASE_BITS-1:0] RADIX_OCT   = 6'd8;
	localparam logic [BASE_BITS-1:0] RADIX_DEC   = 6'd10;
	localparam logic [BASE_BITS-1:0] RADIX_HEX   = 6'd16;
	localparam logic [BASE_BITS-1:0] RADIX_MAX   = 6'd36;
	localparam logic [BASE_BITS-1:0] RESET_BASE  = RADIX_DEC;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] LETTER_OFFSET = 8'd10;

	// one classified character as it travels from front to back
	typedef struct packed {
		logic                last;
		logic                space;
		logic                minus;
		logic                plus;
		logic                zero;
		logic                xchar;
		logic                dig_ok;
		logic [DIG_BITS-1:0] dig;
	} cls_t;

endpackage

>>> rtl/aip_front.sv
module aip_front (
	input  logic         [7:0] ch,
	input  logic               last,
	output aip_pkg::cls_t      cls
);
	import aip_pkg::*;

	logic [7:0] dig_wide;

	always_comb begin
		dig_wide   = 8'd0;
		cls.dig_ok = 1'b0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			dig_wide   = ch - CH_ZERO;
			cls.dig_ok = 1'b1;
		end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
			dig_wide   = ch - CH_LO_A + LETTER_OFFSET;
			cls.dig_ok = 1'b1;
		end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			dig_wide   = ch - CH_UP_A + LETTER_OFFSET;
			cls.dig_ok = 1'b1;
		end
		cls.dig   = dig_wide[DIG_BITS-1:0];
		cls.last  = last;
		// tab, LF, VT, FF and CR are contiguous codes
		cls.space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.minus = (ch == CH_MINUS);
		cls.plus  = (ch == CH_PLUS);
		cls.zero  = (ch == CH_ZERO);
		cls.xchar = (ch == CH_LO_X) || (ch == CH_UP_X);
	end

endmodule

>>> rtl/aip_queue.sv
module aip_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aip_pkg::cls_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output aip_pkg::cls_t rd_data
);
	import aip_pkg::*;

	cls_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full      = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && not_empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full)
		else $error("full queue drained without pop");
`endif

endmodule

>>> rtl/aip_back.sv
module aip_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic          [aip_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic          [aip_pkg::BASE_BITS-1:0] cfg_data,
	input  logic                                   q_valid,
	input  aip_pkg::cls_t                          q_data,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic          [aip_pkg::VALUE_BITS-1:0] out_value,
	output logic          [aip_pkg::POS_BITS-1:0]   out_consumed,
	output logic                                   out_converted,
	output logic                                   out_saturated
);
	import aip_pkg::*;

	typedef enum logic [5:0] {
		PH_OUTER_WS   = 6'b000001,
		PH_INNER_WS   = 6'b000010,
		PH_PREFIX     = 6'b000100,
		PH_AFTER_ZERO = 6'b001000,
		PH_DIGITS     = 6'b010000,
		PH_DONE       = 6'b100000
	} ph_t;

	localparam int PROD_BITS = VALUE_BITS + BASE_BITS;
	localparam logic [VALUE_BITS-1:0] HALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// configuration
	logic [BASE_BITS-1:0] base_q;
	logic                 signed_q;

	// parse engine state
	ph_t                   ph_q;
	logic                  oneg_q, ineg_q, ovf_q, dseen_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [POS_BITS-1:0]   pos_q, epos_q;
	logic [BASE_BITS-1:0]  rad_q;

	// next-state values
	ph_t                   ph_n;
	logic                  oneg_n, ineg_n, ovf_n, dseen_n, taken;
	logic [VALUE_BITS-1:0] acc_n;
	logic [POS_BITS-1:0]   pos_inc, epos_n;
	logic [BASE_BITS-1:0]  rad_n, rad_new, mul_rad;
	logic                  base_bad;
	logic [PROD_BITS-1:0]  mac;
	logic                  mac_ovf;

	// finishing stage
	logic                  fin_valid_s1, fin_move;
	logic                  fin_oneg_s1, fin_ineg_s1, fin_ovf_s1, fin_dseen_s1;
	logic [VALUE_BITS-1:0] fin_acc_s1;
	logic [POS_BITS-1:0]   fin_epos_s1;
	logic [VALUE_BITS-1:0] tmp, limit, res_value;
	logic                  res_sat;

	// output stage
	logic                  out_valid_s2;

	assign base_bad = (base_q == BASE_UNARY) || (base_q > RADIX_MAX);
	assign rad_new  = (base_q == BASE_INFER) ? RADIX_DEC : base_q;
	assign mul_rad  = (ph_q == PH_DIGITS || ph_q == PH_AFTER_ZERO) ? rad_q : rad_new;
	assign mac      = {{BASE_BITS{1'b0}}, acc_q} * {{VALUE_BITS{1'b0}}, mul_rad}
	                + PROD_BITS'(q_data.dig);
	assign mac_ovf  = |mac[PROD_BITS-1:VALUE_BITS];
	assign pos_inc  = (pos_q == MAX_TEXT) ? pos_q : pos_q + 1'b1;

	// one character falls through the phases in a single step
	always_comb begin
		ph_n    = ph_q;
		oneg_n  = oneg_q;
		ineg_n  = ineg_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		dseen_n = dseen_q;
		epos_n  = epos_q;
		rad_n   = rad_q;
		taken   = 1'b0;
		if (ph_n == PH_OUTER_WS) begin
			if (signed_q && q_data.space) begin
				taken = 1'b1;
			end else if (signed_q && q_data.minus) begin
				oneg_n = 1'b1;
				ph_n   = PH_INNER_WS;
				taken  = 1'b1;
			end else if (signed_q && q_data.plus) begin
				ph_n  = PH_INNER_WS;
				taken = 1'b1;
			end else begin
				ph_n = PH_INNER_WS;
			end
		end
		if (!taken && ph_n == PH_INNER_WS) begin
			if (q_data.space) begin
				taken = 1'b1;
			end else if (q_data.minus) begin
				ineg_n = 1'b1;
				ph_n   = PH_PREFIX;
				taken  = 1'b1;
			end else if (q_data.plus) begin
				ph_n  = PH_PREFIX;
				taken = 1'b1;
			end else begin
				ph_n = PH_PREFIX;
			end
		end
		if (!taken && ph_n == PH_PREFIX) begin
			if (base_bad) begin
				rad_n = '0;
				ph_n  = PH_DONE;
				taken = 1'b1;
			end else if ((base_q == BASE_INFER || base_q == RADIX_HEX) && q_data.zero) begin
				dseen_n = 1'b1;
				epos_n  = pos_inc;
				rad_n   = (base_q == BASE_INFER) ? RADIX_OCT : RADIX_HEX;
				ph_n    = PH_AFTER_ZERO;
				taken   = 1'b1;
			end else begin
				rad_n = rad_new;
				ph_n  = PH_DIGITS;
			end
		end
		if (!taken && ph_n == PH_AFTER_ZERO) begin
			if (q_data.xchar) begin
				rad_n = RADIX_HEX;
				taken = 1'b1;
			end
			ph_n = PH_DIGITS;
		end
		if (!taken && ph_n == PH_DIGITS) begin
			if (rad_n >= RADIX_MIN && q_data.dig_ok && q_data.dig < rad_n) begin
				ovf_n   = ovf_q | mac_ovf;
				acc_n   = mac[VALUE_BITS-1:0];
				dseen_n = 1'b1;
				epos_n  = pos_inc;
			end else begin
				ph_n = PH_DONE;
			end
		end
	end

	// a last character needs room in the finishing stage
	assign fin_move = fin_valid_s1 && (!out_valid_s2 || out_ready);
	assign q_pop    = q_valid && (!q_data.last || !fin_valid_s1 || fin_move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= RESET_BASE;
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: base_q   <= cfg_data;
				REG_SIGNED_MODE: signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_OUTER_WS;
			oneg_q  <= 1'b0;
			ineg_q  <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			dseen_q <= 1'b0;
			pos_q   <= '0;
			epos_q  <= '0;
			rad_q   <= '0;
		end else if (q_pop) begin
			if (q_data.last) begin
				ph_q    <= PH_OUTER_WS;
				oneg_q  <= 1'b0;
				ineg_q  <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				dseen_q <= 1'b0;
				pos_q   <= '0;
				epos_q  <= '0;
				rad_q   <= '0;
			end else begin
				ph_q    <= ph_n;
				oneg_q  <= oneg_n;
				ineg_q  <= ineg_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				dseen_q <= dseen_n;
				pos_q   <= pos_inc;
				epos_q  <= epos_n;
				rad_q   <= rad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (q_pop && q_data.last) begin
			fin_valid_s1 <= 1'b1;
		end else if (fin_move) begin
			fin_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			fin_oneg_s1  <= oneg_n;
			fin_ineg_s1  <= ineg_n;
			fin_ovf_s1   <= ovf_n;
			fin_dseen_s1 <= dseen_n;
			fin_acc_s1   <= acc_n;
			fin_epos_s1  <= epos_n;
		end
	end

	// force all ones on overflow, else apply inner sign; then signed clamp and outer sign
	always_comb begin
		res_value = '0;
		res_sat   = 1'b0;
		if (fin_ovf_s1) begin
			tmp = '1;
		end else begin
			tmp = fin_ineg_s1 ? (~fin_acc_s1 + 1'b1) : fin_acc_s1;
		end
		limit = fin_oneg_s1 ? HALF : HALF - 1'b1;
		if (fin_dseen_s1) begin
			res_sat = fin_ovf_s1;
			if (signed_q) begin
				if (tmp > limit) begin
					res_value = limit;
					res_sat   = 1'b1;
				end else begin
					res_value = fin_oneg_s1 ? (~tmp + 1'b1) : tmp;
				end
			end else begin
				res_value = tmp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fin_move) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_move) begin
			out_value     <= res_value;
			out_consumed  <= fin_dseen_s1 ? fin_epos_s1 : '0;
			out_converted <= fin_dseen_s1;
			out_saturated <= res_sat;
		end
	end

	assign out_valid = out_valid_s2;

`ifndef ASSERT_OFF
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_s1 && !fin_move |=> fin_valid_s1)
		else $error("finishing stage dropped a result");
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_data.last |=> fin_valid_s1)
		else $error("last character produced no pending result");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !out_converted |-> out_value == '0 && out_consumed == '0
		&& !out_saturated)
		else $error("unconverted result carries data");
	a_unsigned_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_saturated && !signed_q |-> out_value == '1)
		else $error("unsigned saturation not all ones");
`endif

endmodule

>>> rtl/ascii_integer_parser_unit.sv
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+--------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: ch[7:0]; tlast: last
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: value, consumed; tuser: flags
// cfg      | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One character per cycle sustained while the finishing stage can take each result; the
// combinational multiply-add of the digit accumulator in the parse engine sets that rate.
// A result word is offered once its last character is popped from the queue: the parse
// engine's result is registered in the finishing stage, then in the output register.
// Reset puts the radix at ten, unsigned mode, and an empty parse.
// A four-entry queue between classifier and engine absorbs output stalls; input ready
// drops only when the queue is full. Configuration writes are always ready.
module ascii_integer_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] value, [43:32] consumed, [47:44] zero
	output logic [1:0]  m_axis_tuser,   // [0] converted, [1] saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [aip_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic [aip_pkg::BASE_BITS-1:0] cfg_data
);
	import aip_pkg::*;

	cls_t                  cls, q_data;
	logic                  q_full, q_valid, q_pop;
	logic [VALUE_BITS-1:0] value;
	logic [POS_BITS-1:0]   consumed;
	logic                  converted, saturated;

	// configuration never stalls
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;

	// classify each character as it arrives
	aip_front u_front (
		.ch   (s_axis_tdata),
		.last (s_axis_tlast),
		.cls  (cls)
	);

	// decouple the classifier from the parse engine
	aip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.wr_data   (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_data   (q_data)
	);

	// parse engine, result formation and output register
	aip_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_value     (value),
		.out_consumed  (consumed),
		.out_converted (converted),
		.out_saturated (saturated)
	);

	// pack result fields, lowest first
	assign m_axis_tdata = {4'b0000, consumed, value};
	assign m_axis_tuser = {saturated, converted};

endmodule
